// ===== hw/rtl/sqjd_pkg.sv =====
// shared types and constants for the shortest queue job dispatcher
// no dependencies; imported by every module of the block
`default_nettype none

package sqjd_pkg;

   // fixed field widths
   localparam int PAGE_W      = 4;
   localparam int CNT_W       = 5;
   localparam int CAP_W       = 5;
   localparam int CHOSEN_W    = 2;
   localparam int OUT_QUEUES  = 4;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SERVE
   } sqjd_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic push;
      logic serve;
   } sqjd_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sqjd_ctrl.sv =====
// controller state machine for the shortest queue job dispatcher
// depends on sqjd_pkg; drives push and serve commands to sqjd_datapath
`default_nettype none

module sqjd_ctrl
   import sqjd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output sqjd_cmd_type      cmd,
   output sqjd_state_type    state
);

   sqjd_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.push   = 1'b0;
      cmd.serve  = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.push = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SERVE;
         end
         ST_SERVE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.serve = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result word stays until taken
   always_comb begin
      if (cmd.serve)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign state      = state_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sqjd_datapath.sv =====
// datapath: per-server ring memories, pointers, counters and result register
// depends on sqjd_pkg; commanded by sqjd_ctrl
`default_nettype none

module sqjd_datapath
   import sqjd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int NUM_QUEUES  = 4
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sqjd_cmd_type           cmd,
   input  wire logic                   job_valid,
   input  wire logic [PAGE_W-1:0]      job_pages,
   input  wire logic                   csr_wen,
   input  wire logic [CAP_W-1:0]       csr_wdata,
   output logic [RSP_TDATA_W-1:0]      rsp_word
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QI_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int DW    = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = CNT_W + DW;
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

   logic [CAP_W-1:0]  cap_ff;
   logic [PTR_W-1:0]  head_ff   [NUM_QUEUES];
   logic [PTR_W-1:0]  head_in   [NUM_QUEUES];
   logic [PTR_W-1:0]  tail_ff   [NUM_QUEUES];
   logic [PTR_W-1:0]  tail_in   [NUM_QUEUES];
   logic [CNT_W-1:0]  count_ff  [NUM_QUEUES];
   logic [CNT_W-1:0]  count_in  [NUM_QUEUES];
   logic [PAGE_W-1:0] lpages_ff [NUM_QUEUES];
   logic [PAGE_W-1:0] lpages_in [NUM_QUEUES];
   logic [PAGE_W-1:0] counted_ff[NUM_QUEUES];
   logic [PAGE_W-1:0] counted_in[NUM_QUEUES];
   logic              loaded_ff [NUM_QUEUES];
   logic              loaded_in [NUM_QUEUES];
   logic [PAGE_W-1:0] rdata_ff  [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] write_en;
   logic [NUM_QUEUES-1:0] done_vec;

   logic [QI_W-1:0]   best;
   logic [EXT_W-1:0]  cap_ext;
   logic [EXT_W-1:0]  eff_cap;
   logic              full;
   logic              do_push;

   logic [CHOSEN_W-1:0] chosen_ff;
   logic                dropped_ff;

   logic [CHOSEN_W-1:0]  out_chosen_ff;
   logic                 out_dropped_ff;
   logic [CNT_W-1:0]     out_occ_ff [OUT_QUEUES];
   logic [OUT_QUEUES-1:0] out_done_ff;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset)
         cap_ff <= CAP_RESET;
      else if (csr_wen)
         cap_ff <= csr_wdata;
   end

   // pick the shortest queue, lowest index on ties
   always_comb begin
      best = '0;
      for (int q = 1; q < NUM_QUEUES; q++) begin
         if (count_ff[q] < count_ff[best])
            best = QI_W'(q);
      end
   end

   // capacity check, clamped to the ring depth
   assign cap_ext = EXT_W'(cap_ff);
   assign eff_cap = (cap_ext > DEPTH_EXT) ? DEPTH_EXT : cap_ext;
   assign full    = (EXT_W'(count_ff[best]) >= eff_cap);
   assign do_push = cmd.push && job_valid && !full;

   // choice and drop flag for the word in flight
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         chosen_ff  <= job_valid ? CHOSEN_W'(best) : '0;
         dropped_ff <= job_valid && full;
      end
   end

   // one server per queue: ring memory plus service counters
   for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
      logic [PAGE_W-1:0] mem [QUEUE_DEPTH];

      assign write_en[q] = do_push && (best == QI_W'(q));

      // ring memory, write at tail, registered read at head
      always_ff @(posedge clock) begin
         if (write_en[q])
            mem[tail_ff[q]] <= job_pages;
         rdata_ff[q] <= mem[head_ff[q]];
      end

      // next values: push in the accept cycle, service in the serve cycle
      always_comb begin
         head_in[q]    = head_ff[q];
         tail_in[q]    = tail_ff[q];
         count_in[q]   = count_ff[q];
         lpages_in[q]  = lpages_ff[q];
         counted_in[q] = counted_ff[q];
         loaded_in[q]  = loaded_ff[q];
         done_vec[q]   = 1'b0;
         if (write_en[q]) begin
            tail_in[q]  = (tail_ff[q] == PTR_LAST) ? '0 : tail_ff[q] + PTR_W'(1);
            count_in[q] = count_ff[q] + CNT_W'(1);
         end
         if (cmd.serve && (count_ff[q] != '0)) begin
            if (!loaded_ff[q]) begin
               lpages_in[q] = rdata_ff[q];
               loaded_in[q] = 1'b1;
            end else if (counted_ff[q] != lpages_ff[q]) begin
               counted_in[q] = counted_ff[q] + PAGE_W'(1);
            end else begin
               // last page done: pop and clear the server
               head_in[q]    = (head_ff[q] == PTR_LAST) ? '0 : head_ff[q] + PTR_W'(1);
               count_in[q]   = count_ff[q] - CNT_W'(1);
               loaded_in[q]  = 1'b0;
               lpages_in[q]  = '0;
               counted_in[q] = '0;
               done_vec[q]   = 1'b1;
            end
         end
      end

      // server control registers
      always_ff @(posedge clock) begin
         if (reset) begin
            head_ff[q]    <= '0;
            tail_ff[q]    <= '0;
            count_ff[q]   <= '0;
            lpages_ff[q]  <= '0;
            counted_ff[q] <= '0;
            loaded_ff[q]  <= 1'b0;
         end else begin
            head_ff[q]    <= head_in[q];
            tail_ff[q]    <= tail_in[q];
            count_ff[q]   <= count_in[q];
            lpages_ff[q]  <= lpages_in[q];
            counted_ff[q] <= counted_in[q];
            loaded_ff[q]  <= loaded_in[q];
         end
      end
   end

   // result register, loaded on serve
   always_ff @(posedge clock) begin
      if (cmd.serve) begin
         out_chosen_ff  <= chosen_ff;
         out_dropped_ff <= dropped_ff;
         for (int k = 0; k < OUT_QUEUES; k++) begin
            if (k < NUM_QUEUES) begin
               out_occ_ff[k]  <= count_in[k];
               out_done_ff[k] <= done_vec[k];
            end else begin
               out_occ_ff[k]  <= '0;
               out_done_ff[k] <= 1'b0;
            end
         end
      end
   end

   // pack the result word
   assign rsp_word = {5'b0, out_done_ff, out_occ_ff[3], out_occ_ff[2],
                      out_occ_ff[1], out_occ_ff[0], out_dropped_ff, out_chosen_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/shortest_queue_job_dispatcher_unit.sv =====
// top level of the join-shortest-queue job dispatcher
// depends on sqjd_pkg, sqjd_ctrl and sqjd_datapath
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: job_valid, job_pages
// rsp      out  rsp_tvalid/rsp_tready  tdata: chosen_queue .. done_mask
// csr      in   csr_wen                csr_wdata: queue_capacity
//
// each word passes through accept and enqueue, head read from the ring
// memory, then service and result load; the registered memory read needs the middle step
// a new word is taken while the previous result still waits on rsp
// a result not taken holds the block in its service step
// synchronous reset clears all pointers, counters and the capacity to 10
`default_nettype none

module shortest_queue_job_dispatcher_unit
   import sqjd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int NUM_QUEUES  = 4
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // [0] job_valid, [4:1] job_pages, [7:5] zero
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // [1:0] chosen_queue, [2] job_dropped, [7:3] occupancy_0, [12:8] occupancy_1,
   // [17:13] occupancy_2, [22:18] occupancy_3, [26:23] done_mask, [31:27] zero
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic                    csr_wen,
   input  wire logic [CAP_W-1:0]        csr_wdata
);

   sqjd_cmd_type   cmd;
   sqjd_state_type state;

   // controller
   sqjd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .state      (state)
   );

   // datapath
   sqjd_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_QUEUES  (NUM_QUEUES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .job_valid (req_tdata[0]),
      .job_pages (req_tdata[PAGE_W:1]),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_tdata)
   );

   // an accepted word keeps the input closed for the read and serve steps
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)
      else $error("input reopened before the word was served");

   // a new result only comes out of the service step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state == ST_SERVE))
      else $error("result raised outside the service step");

   // queues 0 and 1 hold no more than the ring depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:3] <= CNT_W'(QUEUE_DEPTH > 31 ? 31 : QUEUE_DEPTH))
                  && (rsp_tdata[12:8] <= CNT_W'(QUEUE_DEPTH > 31 ? 31 : QUEUE_DEPTH)))
      else $error("queue occupancy beyond ring depth");

endmodule

`default_nettype wire
